### rtl/shs_pkg.sv
// Shared types, codes and constants of the switch homing sequencer.
package shs_pkg;

  // Default widths of the position store and the poll counter.
  localparam int unsigned POS_W_DEF = 32;
  localparam int unsigned CNT_W_DEF = 16;

  // Fixed field widths.
  localparam int unsigned SPEED_W    = 31;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned ENC_W      = 32;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 72;

  // Register reset values.
  localparam logic [SPEED_W-1:0]   FAST_SPEED_RST = 31'd3000000;
  localparam logic [SPEED_W-1:0]   SLOW_SPEED_RST = 31'd300000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd6000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_SPEED    = 3'd0,
    CFG_SLOW_SPEED    = 3'd1,
    CFG_AXIS_REVERSED = 3'd2,
    CFG_TIMEOUT_POLLS = 3'd3,
    CFG_ACTIVE_LEVEL  = 3'd4
  } cfg_idx_e;

  typedef enum logic [OP_W-1:0] {
    OP_POLL   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SEARCH  = 2'd1,
    PH_RELEASE = 2'd2
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE       = 3'd0,
    ST_DONE       = 3'd1,
    ST_SEARCH_TO  = 3'd2,
    ST_RELEASE_TO = 3'd3,
    ST_READ_FAIL  = 3'd4,
    ST_CANCELLED  = 3'd5,
    ST_BUSY       = 3'd6
  } status_e;

  // What one item does to the sequence.
  typedef enum logic [3:0] {
    EV_NONE,
    EV_REJECT,
    EV_FAIL,
    EV_CANCEL,
    EV_HALT,
    EV_SEARCH,
    EV_RELEASE,
    EV_COUNT,
    EV_DONE,
    EV_SEARCH_TO,
    EV_RELEASE_TO
  } evt_e;

  typedef struct packed {
    logic [SPEED_W-1:0]   fast_speed;
    logic [SPEED_W-1:0]   slow_speed;
    logic                 axis_reversed;
    logic [TIMEOUT_W-1:0] timeout_polls;
    logic                 active_level;
  } cfg_t;

endpackage

### rtl/switch_homing_sequencer_core.sv
// Top level of the switch homing sequencer: input stage, state and result stage.
//
// Channel  Dir  Payload                                          Handshake
// s_axis   in   tuser: operation; tdata: level, read ok, encoder tvalid/tready
// m_axis   out  tuser: status; tdata: velocity, busy, strobe, offset  tvalid/tready
// cfg      in   register index and write data                    cfg_we_i only
//
// One item per cycle sustained while m_axis_tready is high; each item passes
// through the input register and then the result register to its result. The
// sequence state is updated once per item as it moves into the result
// register. Reset clears the sequence state and both stages and loads the
// register defaults. A stalled result holds in its register while one more
// item waits in the input register; only then does s_axis_tready drop.
module switch_homing_sequencer_core import shs_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = POS_W_DEF,
  parameter int unsigned COUNT_WIDTH    = CNT_W_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: sensor_level[0], sensor_read_ok[1], encoder_count[33:2], zeros[39:34]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: velocity_command[31:0], busy_res[32], offset_valid[33],
  //        offset_value[65:34], zeros[71:66]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  cfg_t cfg;

  // Input stage.
  logic                  in_valid_q;
  logic [OP_W-1:0]       op_q;
  logic                  level_q;
  logic                  read_ok_q;
  logic signed [ENC_W-1:0] enc_q;

  // Sequence state.
  phase_e                    phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]    poll_count_q, poll_count_d;
  logic [POSITION_WIDTH-1:0] zero_offset_q, zero_offset_d;
  logic [VEL_W-1:0]          drive_vel_q, drive_vel_d;
  status_e                   status_d;
  logic                      latched_d;

  // Result stage.
  logic                  out_valid_q;
  logic [VEL_W-1:0]      res_vel_q;
  logic                  res_busy_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic                  res_latched_q;
  logic [ENC_W-1:0]      res_offset_q;

  logic advance;
  logic in_accept;

  shs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  shs_step #(
    .POS_W(POSITION_WIDTH),
    .CNT_W(COUNT_WIDTH)
  ) u_step (
    .cfg_i           (cfg),
    .op_i            (op_q),
    .sensor_level_i  (level_q),
    .sensor_read_ok_i(read_ok_q),
    .encoder_count_i (enc_q),
    .phase_i         (phase_q),
    .poll_count_i    (poll_count_q),
    .zero_offset_i   (zero_offset_q),
    .drive_vel_i     (drive_vel_q),
    .phase_o         (phase_d),
    .poll_count_o    (poll_count_d),
    .zero_offset_o   (zero_offset_d),
    .drive_vel_o     (drive_vel_d),
    .status_o        (status_d),
    .latched_o       (latched_d)
  );

  // An item moves on when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= s_axis_tuser;
      level_q   <= s_axis_tdata[0];
      read_ok_q <= s_axis_tdata[1];
      enc_q     <= s_axis_tdata[ENC_W+1:2];
    end
  end

  // Sequence state, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      poll_count_q  <= '0;
      zero_offset_q <= '0;
      drive_vel_q   <= '0;
    end else if (advance) begin
      phase_q       <= phase_d;
      poll_count_q  <= poll_count_d;
      zero_offset_q <= zero_offset_d;
      drive_vel_q   <= drive_vel_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_vel_q     <= drive_vel_d;
      res_busy_q    <= (phase_d != PH_IDLE);
      res_status_q  <= status_d;
      res_latched_q <= latched_d;
      res_offset_q  <= ENC_W'(zero_offset_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_status_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - VEL_W - ENC_W - 2){1'b0}},
                          res_offset_q, res_latched_q, res_busy_q, res_vel_q};

  // A latched offset is only ever reported with the done status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[VEL_W+1]) |-> (m_axis_tuser == ST_DONE))
    else $error("offset strobe without done status");

  // An idle result never commands motion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[VEL_W]) |-> (m_axis_tdata[VEL_W-1:0] == '0))
    else $error("velocity commanded while not busy");

  // Idle state keeps the counter and the drive velocity cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (drive_vel_q == '0 && poll_count_q == '0))
    else $error("idle state with stale counter or velocity");

  // The input side only stalls when both stages are full and the output waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

endmodule

### rtl/shs_cfg_regs.sv
// Configuration registers of the switch homing sequencer.
module shs_cfg_regs import shs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode one write into the addressed register; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FAST_SPEED:    cfg_d.fast_speed    = cfg_wdata_i[SPEED_W-1:0];
        CFG_SLOW_SPEED:    cfg_d.slow_speed    = cfg_wdata_i[SPEED_W-1:0];
        CFG_AXIS_REVERSED: cfg_d.axis_reversed = cfg_wdata_i[0];
        CFG_TIMEOUT_POLLS: cfg_d.timeout_polls = cfg_wdata_i[TIMEOUT_W-1:0];
        CFG_ACTIVE_LEVEL:  cfg_d.active_level  = cfg_wdata_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_speed    <= FAST_SPEED_RST;
      cfg_q.slow_speed    <= SLOW_SPEED_RST;
      cfg_q.axis_reversed <= 1'b0;
      cfg_q.timeout_polls <= TIMEOUT_RST;
      cfg_q.active_level  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/shs_step.sv
// Next-state and result logic for one item of the homing sequence.
module shs_step import shs_pkg::*; #(
  parameter int unsigned POS_W = POS_W_DEF,
  parameter int unsigned CNT_W = CNT_W_DEF
) (
  input  cfg_t                cfg_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic                sensor_level_i,
  input  logic                sensor_read_ok_i,
  input  logic signed [ENC_W-1:0] encoder_count_i,
  input  phase_e              phase_i,
  input  logic [CNT_W-1:0]    poll_count_i,
  input  logic [POS_W-1:0]    zero_offset_i,
  input  logic [VEL_W-1:0]    drive_vel_i,
  output phase_e              phase_o,
  output logic [CNT_W-1:0]    poll_count_o,
  output logic [POS_W-1:0]    zero_offset_o,
  output logic [VEL_W-1:0]    drive_vel_o,
  output status_e             status_o,
  output logic                latched_o
);

  localparam int unsigned CMP_W = (CNT_W > TIMEOUT_W) ? CNT_W : TIMEOUT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic             triggered;
  logic [CNT_W-1:0] poll_inc;
  logic             timed_out;
  logic [VEL_W-1:0] fast_vel, slow_vel, search_vel, release_vel;
  evt_e             evt;

  assign triggered = (sensor_level_i == cfg_i.active_level);

  // Poll counter saturates at its top; reaching the top also times out.
  assign poll_inc  = (poll_count_i != CNT_MAX) ? poll_count_i + 1'b1 : poll_count_i;
  assign timed_out = (CMP_W'(poll_inc) >= CMP_W'(cfg_i.timeout_polls)) ||
                     (poll_inc == CNT_MAX);

  // Search runs in the negative common direction, release in the positive one.
  assign fast_vel    = VEL_W'(cfg_i.fast_speed);
  assign slow_vel    = VEL_W'(cfg_i.slow_speed);
  assign search_vel  = cfg_i.axis_reversed ? fast_vel : (~fast_vel + 1'b1);
  assign release_vel = cfg_i.axis_reversed ? (~slow_vel + 1'b1) : slow_vel;

  // Decide what this item does. A failed read wins over the switch check,
  // and the switch check wins over the timeout.
  always_comb begin
    evt = EV_NONE;
    unique case (op_e'(op_i))
      OP_START: begin
        if (phase_i != PH_IDLE) evt = EV_REJECT;
        else if (!sensor_read_ok_i) evt = EV_FAIL;
        else if (triggered) evt = EV_RELEASE;
        else evt = EV_SEARCH;
      end
      OP_CANCEL: begin
        if (phase_i != PH_IDLE) evt = EV_CANCEL;
      end
      OP_POLL: begin
        unique case (phase_i)
          PH_SEARCH: begin
            if (!sensor_read_ok_i) evt = EV_FAIL;
            else if (triggered) evt = EV_RELEASE;
            else if (timed_out) evt = EV_SEARCH_TO;
            else evt = EV_COUNT;
          end
          PH_RELEASE: begin
            if (!sensor_read_ok_i) evt = EV_FAIL;
            else if (!triggered) evt = EV_DONE;
            else if (timed_out) evt = EV_RELEASE_TO;
            else evt = EV_COUNT;
          end
          default: evt = EV_HALT;
        endcase
      end
      default: evt = EV_NONE;
    endcase
  end

  // Next state of the sequence.
  always_comb begin
    phase_o       = phase_i;
    poll_count_o  = poll_count_i;
    zero_offset_o = zero_offset_i;
    drive_vel_o   = drive_vel_i;
    unique case (evt)
      EV_NONE, EV_REJECT: begin
      end
      EV_FAIL, EV_CANCEL, EV_HALT, EV_SEARCH_TO, EV_RELEASE_TO: begin
        phase_o      = PH_IDLE;
        poll_count_o = '0;
        drive_vel_o  = '0;
      end
      EV_DONE: begin
        phase_o       = PH_IDLE;
        poll_count_o  = '0;
        drive_vel_o   = '0;
        zero_offset_o = POS_W'(encoder_count_i);
      end
      EV_SEARCH: begin
        phase_o      = PH_SEARCH;
        poll_count_o = '0;
        drive_vel_o  = search_vel;
      end
      EV_RELEASE: begin
        phase_o      = PH_RELEASE;
        poll_count_o = '0;
        drive_vel_o  = release_vel;
      end
      EV_COUNT: begin
        poll_count_o = poll_inc;
      end
      default: begin
      end
    endcase
  end

  // Status code and offset strobe of the result.
  always_comb begin
    latched_o = (evt == EV_DONE);
    unique case (evt)
      EV_REJECT:     status_o = ST_BUSY;
      EV_FAIL:       status_o = ST_READ_FAIL;
      EV_CANCEL:     status_o = ST_CANCELLED;
      EV_DONE:       status_o = ST_DONE;
      EV_SEARCH_TO:  status_o = ST_SEARCH_TO;
      EV_RELEASE_TO: status_o = ST_RELEASE_TO;
      default:       status_o = ST_NONE;
    endcase
  end

endmodule
